// ===== src/iir_notch_filter_fourth_order_top_assert.svh =====
// Assertion macros shared by the notch filter RTL.
`ifndef IIR_NOTCH_FILTER_FOURTH_ORDER_TOP_ASSERT_SVH
`define IIR_NOTCH_FILTER_FOURTH_ORDER_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define IIRN4_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iirn4 check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define IIRN4_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iirn4 check failed");

`endif

// ===== src/iirn4_pkg.sv =====
// Types and constants of the fourth-order notch filter.
`timescale 1ns / 1ps
package iirn4_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 24;
	localparam int FRAC_BITS = 20;
	localparam int NUM_COEF  = 7;
	localparam int HIST_D    = 4;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 5;
	localparam int IDX_W     = 3;
	localparam int PRE_W     = SAMPLE_W + 1;
	localparam int PROD_W    = PRE_W + COEF_W;
	localparam int ACC_W     = PROD_W + 7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PRE_W-1:0]    pre_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic [IDX_W-1:0]           reg_idx_t;

	// Register indexes.
	localparam reg_idx_t REG_B0 = 3'd0;
	localparam reg_idx_t REG_B1 = 3'd1;
	localparam reg_idx_t REG_B2 = 3'd2;
	localparam reg_idx_t REG_A1 = 3'd3;

	localparam coef_t   COEF_ONE   = coef_t'(2 ** FRAC_BITS);
	localparam acc_t    ROUND_HALF = acc_t'(2 ** (FRAC_BITS - 1));
	localparam acc_t    ACC_MAX    = acc_t'(2 ** (SAMPLE_W - 1) - 1);
	localparam acc_t    ACC_MIN    = acc_t'(-(2 ** (SAMPLE_W - 1)));
	localparam sample_t SAMPLE_MAX = sample_t'(2 ** (SAMPLE_W - 1) - 1);
	localparam sample_t SAMPLE_MIN = sample_t'(-(2 ** (SAMPLE_W - 1)));

endpackage

// ===== src/iir_notch_filter_fourth_order_top.sv =====
// Fourth-order direct form I IIR notch filter with symmetric numerator and APB coefficients.
// An input beat passes through the input register, then the result register, to the output.
// Throughput: one beat per cycle unless the output stalls; history feedback adds no bubble.
// The result register lets a new input beat enter while a finished beat waits on the output.
// Reset clears the histories and handshake state and loads b0 = 1.0, other taps zero.
`timescale 1ns / 1ps
`include "iir_notch_filter_fourth_order_top_assert.svh"

module iir_notch_filter_fourth_order_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [iirn4_pkg::APB_AW-1:0]    paddr,
	input  logic [iirn4_pkg::APB_DW-1:0]    pwdata,
	output logic [iirn4_pkg::APB_DW-1:0]    prdata,
	output logic                            pready,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [iirn4_pkg::SAMPLE_W-1:0]  s_axis_tdata,  // [15:0] sample_in
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [iirn4_pkg::SAMPLE_W-1:0]  m_axis_tdata,  // [15:0] sample_out
	output logic                            m_axis_tuser   // [0] clipped
);

	iirn4_pkg::coef_t   coef_q [iirn4_pkg::NUM_COEF];
	iirn4_pkg::sample_t xh_q [iirn4_pkg::HIST_D];
	iirn4_pkg::sample_t yh_q [iirn4_pkg::HIST_D];
	iirn4_pkg::sample_t sample_s1;
	logic               valid_s1;
	logic               m_valid_q;
	iirn4_pkg::sample_t out_q;
	logic               clip_q;

	iirn4_pkg::reg_idx_t idx;
	logic                cfg_wr;
	logic                s_accept;
	logic                advance;

	iirn4_pkg::pre_t  pre_outer;
	iirn4_pkg::pre_t  pre_inner;
	iirn4_pkg::prod_t prod_b0;
	iirn4_pkg::prod_t prod_b1;
	iirn4_pkg::prod_t prod_b2;
	iirn4_pkg::prod_t prod_a [iirn4_pkg::HIST_D];
	iirn4_pkg::acc_t  acc_sum;
	iirn4_pkg::acc_t  acc_rnd;
	iirn4_pkg::sample_t y_sat;
	logic               y_clip;

	// Configuration port.
	assign pready = 1'b1;
	assign idx    = paddr[iirn4_pkg::APB_AW-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (idx < iirn4_pkg::reg_idx_t'(iirn4_pkg::NUM_COEF)) begin
			prdata = {{(iirn4_pkg::APB_DW - iirn4_pkg::COEF_W){1'b0}}, coef_q[idx]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < iirn4_pkg::NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[iirn4_pkg::REG_B0] <= iirn4_pkg::COEF_ONE;
		end else if (cfg_wr && idx < iirn4_pkg::reg_idx_t'(iirn4_pkg::NUM_COEF)) begin
			coef_q[idx] <= pwdata[iirn4_pkg::COEF_W-1:0];
		end
	end

	// Handshake: the input stage moves on whenever the result register is free or drains.
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			sample_s1 <= s_axis_tdata;
		end
	end

	// Symmetric numerator: pair taps 0/4 and 1/3 before multiplying.
	assign pre_outer = iirn4_pkg::pre_t'(sample_s1) + iirn4_pkg::pre_t'(xh_q[3]);
	assign pre_inner = iirn4_pkg::pre_t'(xh_q[0]) + iirn4_pkg::pre_t'(xh_q[2]);
	assign prod_b0   = iirn4_pkg::prod_t'(pre_outer) * iirn4_pkg::prod_t'(coef_q[iirn4_pkg::REG_B0]);
	assign prod_b1   = iirn4_pkg::prod_t'(pre_inner) * iirn4_pkg::prod_t'(coef_q[iirn4_pkg::REG_B1]);
	assign prod_b2   = iirn4_pkg::prod_t'(xh_q[1]) * iirn4_pkg::prod_t'(coef_q[iirn4_pkg::REG_B2]);

	always_comb begin
		for (int i = 0; i < iirn4_pkg::HIST_D; i++) begin
			prod_a[i] = iirn4_pkg::prod_t'(yh_q[i])
				* iirn4_pkg::prod_t'(coef_q[iirn4_pkg::REG_A1 + iirn4_pkg::reg_idx_t'(i)]);
		end
	end

	always_comb begin
		acc_sum = iirn4_pkg::acc_t'(prod_b0) + iirn4_pkg::acc_t'(prod_b1)
			+ iirn4_pkg::acc_t'(prod_b2) + iirn4_pkg::ROUND_HALF;
		for (int i = 0; i < iirn4_pkg::HIST_D; i++) begin
			acc_sum = acc_sum - iirn4_pkg::acc_t'(prod_a[i]);
		end
	end

	assign acc_rnd = acc_sum >>> iirn4_pkg::FRAC_BITS;

	always_comb begin
		priority if (acc_rnd > iirn4_pkg::ACC_MAX) begin
			y_sat  = iirn4_pkg::SAMPLE_MAX;
			y_clip = 1'b1;
		end else if (acc_rnd < iirn4_pkg::ACC_MIN) begin
			y_sat  = iirn4_pkg::SAMPLE_MIN;
			y_clip = 1'b1;
		end else begin
			y_sat  = acc_rnd[iirn4_pkg::SAMPLE_W-1:0];
			y_clip = 1'b0;
		end
	end

	// Histories shift only when a sample completes, so the next sample sees them at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < iirn4_pkg::HIST_D; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else if (advance) begin
			for (int i = iirn4_pkg::HIST_D - 1; i > 0; i--) begin
				xh_q[i] <= xh_q[i-1];
				yh_q[i] <= yh_q[i-1];
			end
			xh_q[0] <= sample_s1;
			yh_q[0] <= y_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q  <= y_sat;
			clip_q <= y_clip;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tuser  = clip_q;

	`IIRN4_ASSERT_NOW(a_clip_at_rail, m_valid_q && clip_q, out_q == iirn4_pkg::SAMPLE_MAX || out_q == iirn4_pkg::SAMPLE_MIN)
	`IIRN4_ASSERT_NOW(a_stall_means_busy, !s_axis_tready, valid_s1 && m_valid_q)
	`IIRN4_ASSERT_NEXT(a_stage_held, valid_s1 && !advance, valid_s1)
	`IIRN4_ASSERT_NEXT(a_result_shown, advance, m_valid_q && yh_q[0] == out_q)

endmodule
